// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Every property is sampled on clk and
// disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge.
`define RRP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in this cycle implies the consequent in the same cycle.
`define RRP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent in this cycle implies the consequent in the next cycle.
`define RRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rrp_pkg.sv =====
package rrp_pkg;

  localparam int MAX_ARG_COUNT_DEF = 16;
  localparam int BUF_BYTES_DEF = 4096;
  localparam logic [4:0] ARG_LIMIT_RESET = 5'd16;

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_HEADER = 3'd1,
    EV_DATA   = 3'd2,
    EV_DONE   = 3'd3,
    EV_ERROR  = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    ERR_PREFIX      = 3'd0,
    ERR_COUNT_DIGIT = 3'd1,
    ERR_COUNT_RANGE = 3'd2,
    ERR_NO_DOLLAR   = 3'd3,
    ERR_LEN_DIGIT   = 3'd4,
    ERR_NO_LF       = 3'd5,
    ERR_TOO_LONG    = 3'd6
  } err_t;

  typedef enum logic [9:0] {
    PH_STAR     = 10'b00_0000_0001,
    PH_COUNT    = 10'b00_0000_0010,
    PH_COUNT_LF = 10'b00_0000_0100,
    PH_DOLLAR   = 10'b00_0000_1000,
    PH_LEN      = 10'b00_0001_0000,
    PH_LEN_LF   = 10'b00_0010_0000,
    PH_DATA     = 10'b00_0100_0000,
    PH_TRAIL1   = 10'b00_1000_0000,
    PH_TRAIL2   = 10'b01_0000_0000,
    PH_STUCK    = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic       restart;
    logic [7:0] in_byte;
  } item_t;

  typedef struct packed {
    err_t        error_code;
    logic [4:0]  arg_total;
    logic        last_of_arg;
    logic [11:0] arg_length;
    logic [3:0]  arg_index;
    logic [7:0]  data_byte;
    event_t      event_kind;
  } result_t;

endpackage

// ===== rtl/resp_request_parser_core.sv =====
// Channel  Dir  Signals                              Contents
// s        in   s_tvalid s_tready s_tdata s_tuser    one received byte, restart flag
// m        out  m_tvalid m_tready m_tdata m_tuser    one parse event per received byte
//                m_tlast
// cfg      in   cfg_we cfg_wdata                     argument count limit
//
// The core takes one byte per cycle while its result register has room and
// gives exactly one result per byte. A byte is held in the input register,
// then the parser update runs in a single combinational pass into the result
// register, from which the result is offered on the m channel.
// Reset clears the parser to wait for a new request and sets the argument
// count limit to 16.
// While m_tready is low the result register holds; one further byte can
// still be taken into the input register, after which s_tready drops.
module resp_request_parser_core #(
  parameter int MAX_ARG_COUNT = rrp_pkg::MAX_ARG_COUNT_DEF,
  parameter int BUF_BYTES = rrp_pkg::BUF_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic [0:0]  s_tuser,   // [0] restart
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] data_byte, [11:8] arg_index,
                                 // [23:12] arg_length, [28:24] arg_total,
                                 // [31:29] error_code
  output logic [2:0]  m_tuser,   // [2:0] event_kind
  output logic        m_tlast,   // last_of_arg
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata  // arg_limit
);

  logic             item_valid;
  rrp_pkg::item_t   item;
  rrp_pkg::result_t result;
  logic             room;
  logic             advance;

  // A byte moves through the parser whenever the result register can take
  // its result: either it is empty or its current transfer completes now.
  assign advance = item_valid && room;

  rrp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .take       (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // Parser state only changes on the cycle a byte is consumed, so the
  // result and the state update always come from the same byte.
  rrp_parser #(
    .MAX_ARG_COUNT (MAX_ARG_COUNT),
    .BUF_BYTES     (BUF_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .item      (item),
    .result    (result)
  );

  rrp_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .result   (result),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== rtl/rrp_in_stage.sv =====
// Input register: holds one received transfer until the parser takes it.
module rrp_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [7:0]     s_tdata,
  input  logic [0:0]     s_tuser,
  input  logic           take,
  output logic           item_valid,
  output rrp_pkg::item_t item
);

  assign s_tready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.in_byte <= s_tdata;
      item.restart <= s_tuser[0];
    end
  end

endmodule

// ===== rtl/rrp_parser.sv =====
`include "assert_macros.svh"

// Request parser state and the single-pass update for one byte.
module rrp_parser #(
  parameter int MAX_ARG_COUNT = rrp_pkg::MAX_ARG_COUNT_DEF,
  parameter int BUF_BYTES = rrp_pkg::BUF_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [4:0]       cfg_wdata,
  input  logic             step,
  input  rrp_pkg::item_t   item,
  output rrp_pkg::result_t result
);

  localparam int RBW = $clog2(BUF_BYTES + 1);
  localparam logic [RBW-1:0] BUF_MAX = RBW'(BUF_BYTES);

  logic [4:0]     arg_limit;
  rrp_pkg::phase_t phase, phase_next;
  logic [4:0]     count_accum, count_accum_next;
  logic [4:0]     args_done, args_done_next;
  logic [RBW-1:0] length_accum, length_accum_next;
  logic [RBW-1:0] bytes_left, bytes_left_next;
  logic [RBW-1:0] request_bytes, request_bytes_next;

  logic           is_digit;
  logic [3:0]     digit;
  logic [8:0]     count_mul;
  logic [RBW+3:0] len_mul;
  logic [RBW+1:0] len_total;
  logic [4:0]     args_inc;
  logic [RBW-1:0] rb_inc;
  logic           count_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      arg_limit <= rrp_pkg::ARG_LIMIT_RESET;
    end else if (cfg_we) begin
      arg_limit <= cfg_wdata;
    end
  end

  assign is_digit  = item.in_byte >= rrp_pkg::CH_ZERO && item.in_byte <= rrp_pkg::CH_NINE;
  assign digit     = 4'(item.in_byte - rrp_pkg::CH_ZERO);
  assign count_mul = ({4'd0, count_accum} << 3) + ({4'd0, count_accum} << 1) + {5'd0, digit};
  assign len_mul   = ({4'd0, length_accum} << 3) + ({4'd0, length_accum} << 1)
                   + (RBW+4)'(digit);
  assign rb_inc    = request_bytes + 1'b1;
  assign len_total = {2'b00, rb_inc} + {2'b00, length_accum} + (RBW+2)'(2);
  assign args_inc  = args_done + 1'b1;
  assign count_bad = count_accum == 5'd0 || count_accum == 5'd31 || count_accum > arg_limit
                  || {2'b00, count_accum} > 7'(MAX_ARG_COUNT);

  always_comb begin
    phase_next         = phase;
    count_accum_next   = count_accum;
    args_done_next     = args_done;
    length_accum_next  = length_accum;
    bytes_left_next    = bytes_left;
    request_bytes_next = request_bytes;
    result             = '0;
    result.event_kind  = rrp_pkg::EV_NONE;
    result.error_code  = rrp_pkg::ERR_PREFIX;

    if (item.restart) begin
      phase_next         = rrp_pkg::PH_STAR;
      count_accum_next   = '0;
      args_done_next     = '0;
      length_accum_next  = '0;
      bytes_left_next    = '0;
      request_bytes_next = '0;
    end else if (phase != rrp_pkg::PH_STUCK) begin
      if (request_bytes >= BUF_MAX) begin
        result.event_kind = rrp_pkg::EV_ERROR;
        result.error_code = rrp_pkg::ERR_TOO_LONG;
      end else begin
        request_bytes_next = rb_inc;
        unique case (phase)
          rrp_pkg::PH_STAR: begin
            if (item.in_byte == rrp_pkg::CH_STAR) begin
              phase_next       = rrp_pkg::PH_COUNT;
              count_accum_next = '0;
            end else begin
              result.event_kind = rrp_pkg::EV_ERROR;
              result.error_code = rrp_pkg::ERR_PREFIX;
            end
          end
          rrp_pkg::PH_COUNT: begin
            if (item.in_byte == rrp_pkg::CH_CR) begin
              phase_next = rrp_pkg::PH_COUNT_LF;
            end else if (is_digit) begin
              count_accum_next = (count_mul > 9'd31) ? 5'd31 : count_mul[4:0];
            end else begin
              result.event_kind = rrp_pkg::EV_ERROR;
              result.error_code = rrp_pkg::ERR_COUNT_DIGIT;
            end
          end
          rrp_pkg::PH_COUNT_LF: begin
            if (item.in_byte != rrp_pkg::CH_LF) begin
              result.event_kind = rrp_pkg::EV_ERROR;
              result.error_code = rrp_pkg::ERR_NO_LF;
            end else if (count_bad) begin
              result.event_kind = rrp_pkg::EV_ERROR;
              result.error_code = rrp_pkg::ERR_COUNT_RANGE;
            end else begin
              phase_next = rrp_pkg::PH_DOLLAR;
            end
          end
          rrp_pkg::PH_DOLLAR: begin
            if (item.in_byte == rrp_pkg::CH_DOLLAR) begin
              phase_next        = rrp_pkg::PH_LEN;
              length_accum_next = '0;
            end else begin
              result.event_kind = rrp_pkg::EV_ERROR;
              result.error_code = rrp_pkg::ERR_NO_DOLLAR;
            end
          end
          rrp_pkg::PH_LEN: begin
            if (item.in_byte == rrp_pkg::CH_CR) begin
              phase_next = rrp_pkg::PH_LEN_LF;
            end else if (is_digit) begin
              length_accum_next = (len_mul > (RBW+4)'(BUF_BYTES)) ? BUF_MAX : len_mul[RBW-1:0];
            end else begin
              result.event_kind = rrp_pkg::EV_ERROR;
              result.error_code = rrp_pkg::ERR_LEN_DIGIT;
            end
          end
          rrp_pkg::PH_LEN_LF: begin
            if (item.in_byte != rrp_pkg::CH_LF) begin
              result.event_kind = rrp_pkg::EV_ERROR;
              result.error_code = rrp_pkg::ERR_NO_LF;
            end else if (len_total > (RBW+2)'(BUF_BYTES)) begin
              result.event_kind = rrp_pkg::EV_ERROR;
              result.error_code = rrp_pkg::ERR_TOO_LONG;
            end else begin
              result.event_kind = rrp_pkg::EV_HEADER;
              result.arg_length = 12'(length_accum);
              bytes_left_next   = length_accum;
              phase_next = (length_accum == '0) ? rrp_pkg::PH_TRAIL1 : rrp_pkg::PH_DATA;
            end
          end
          rrp_pkg::PH_DATA: begin
            result.event_kind = rrp_pkg::EV_DATA;
            result.data_byte  = item.in_byte;
            if (bytes_left <= RBW'(1)) begin
              result.last_of_arg = 1'b1;
              bytes_left_next    = '0;
              phase_next         = rrp_pkg::PH_TRAIL1;
            end else begin
              bytes_left_next = bytes_left - 1'b1;
            end
          end
          rrp_pkg::PH_TRAIL1: begin
            phase_next = rrp_pkg::PH_TRAIL2;
          end
          rrp_pkg::PH_TRAIL2: begin
            if (args_inc >= count_accum) begin
              // Last trailer of the last argument: report and start over.
              result.event_kind  = rrp_pkg::EV_DONE;
              result.arg_total   = count_accum;
              phase_next         = rrp_pkg::PH_STAR;
              count_accum_next   = '0;
              args_done_next     = '0;
              length_accum_next  = '0;
              bytes_left_next    = '0;
              request_bytes_next = '0;
            end else begin
              args_done_next = args_inc;
              phase_next     = rrp_pkg::PH_DOLLAR;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
      if (result.event_kind == rrp_pkg::EV_ERROR) begin
        phase_next = rrp_pkg::PH_STUCK;
      end
    end
    result.arg_index = args_done_next[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= rrp_pkg::PH_STAR;
      count_accum   <= '0;
      args_done     <= '0;
      length_accum  <= '0;
      bytes_left    <= '0;
      request_bytes <= '0;
    end else if (step) begin
      phase         <= phase_next;
      count_accum   <= count_accum_next;
      args_done     <= args_done_next;
      length_accum  <= length_accum_next;
      bytes_left    <= bytes_left_next;
      request_bytes <= request_bytes_next;
    end
  end

  `RRP_ASSERT_NEXT(a_stuck_holds, step && !item.restart && phase == rrp_pkg::PH_STUCK, phase == rrp_pkg::PH_STUCK, "parser left the error state without a restart")
  `RRP_ASSERT_ALWAYS(a_req_bytes_bound, request_bytes <= BUF_MAX, "request byte count beyond buffer size")
  `RRP_ASSERT_ALWAYS(a_len_bound, length_accum <= BUF_MAX, "length accumulator beyond buffer size")
  `RRP_ASSERT_ALWAYS(a_args_bound, args_done <= count_accum, "argument index passed the argument count")

endmodule

// ===== rtl/rrp_out_stage.sv =====
// Result register: holds one result until the downstream side takes it.
module rrp_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  rrp_pkg::result_t result,
  output logic             room,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata,
  output logic [2:0]       m_tuser,
  output logic             m_tlast
);

  rrp_pkg::result_t held;

  assign room = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign m_tdata = {held.error_code, held.arg_total, held.arg_length,
                    held.arg_index, held.data_byte};
  assign m_tuser = held.event_kind;
  assign m_tlast = held.last_of_arg;

endmodule
